>>> hw/rtl/bucd_pkg.sv
// Shared types, constants and a helper function of the battery undervoltage lockout block.
package bucd_pkg;

    localparam int AdcW      = 12;
    localparam int BusW      = 16;
    localparam int LevelW    = 17;
    localparam int CellMvW   = 13;
    localparam int DebW      = 16;
    localparam int CountW    = 4;
    localparam int StampW    = 32;
    localparam int ProdW     = 21;
    localparam int RecipW    = 22;
    localparam int ScaledW   = ProdW + RecipW;
    localparam int ScaleSh   = 27;
    localparam int QuoW      = CountW + 1;
    localparam int DivW      = LevelW;
    localparam int AddrW     = 5;
    localparam int DataW     = 32;
    localparam int IdxW      = 3;

    localparam logic [8:0]        MulAdc   = 9'd437;
    localparam logic [RecipW-1:0] RecipM   = 22'd2855697;
    localparam logic [BusW-1:0]   BusMax   = 16'd38075;
    localparam logic [QuoW-1:0]   QuoSat   = 5'h10;
    localparam logic [2:0]        DivSteps = 3'd5;

    localparam logic [CellMvW-1:0] RstFullMv    = 13'd4200;
    localparam logic [CellMvW-1:0] RstCutoffMv  = 13'd3300;
    localparam logic [CellMvW-1:0] RstRecoverMv = 13'd3500;
    localparam logic [DebW-1:0]    RstDebMs     = 16'd100;
    localparam logic [CountW-1:0]  RstMinCells  = 4'd4;
    localparam logic [CountW-1:0]  RstMaxCells  = 4'd6;

    localparam logic [IdxW-1:0] RegFullMv    = 3'd0;
    localparam logic [IdxW-1:0] RegCutoffMv  = 3'd1;
    localparam logic [IdxW-1:0] RegRecoverMv = 3'd2;
    localparam logic [IdxW-1:0] RegDebMs     = 3'd3;
    localparam logic [IdxW-1:0] RegMinCells  = 3'd4;
    localparam logic [IdxW-1:0] RegMaxCells  = 3'd5;

    typedef struct packed {
        logic [CellMvW-1:0] cell_full_mv;
        logic [CellMvW-1:0] cell_cutoff_mv;
        logic [CellMvW-1:0] cell_recover_mv;
        logic [DebW-1:0]    debounce_ms;
        logic [CountW-1:0]  min_cells;
        logic [CountW-1:0]  max_cells;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic scale_mul;
        logic scale_div;
        logic tick_upd;
        logic div_start_a;
        logic div_start_b;
        logic take_a;
        logic detect_fin;
        logic levels;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic opcode;
        logic div_done;
    } t_status;

    function automatic logic [CountW-1:0] clamp_count(input logic [QuoW-1:0] v,
                                                      input logic [CountW-1:0] lo,
                                                      input logic [CountW-1:0] hi);
        logic [CountW-1:0] res;
        if (v < {1'b0, lo}) begin
            res = lo;
        end else if (v > {1'b0, hi}) begin
            res = hi;
        end else begin
            res = v[CountW-1:0];
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/bucd_div.sv
// Iterative divider that gives a quotient saturated at sixteen, one trial subtraction a cycle.
module bucd_div
    import bucd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DivW-1:0]   i_dividend,
    input  logic [CellMvW-1:0] i_divisor,
    output logic              o_done,
    output logic [QuoW-1:0]   o_quo
);

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic              r_done;
    logic [DivW-1:0]   r_rem;
    logic [CellMvW-1:0] r_dvs;
    logic [QuoW-1:0]   r_quo;

    logic [2:0]        w_shift;
    logic [DivW:0]     w_trial;
    logic              w_ge;

    assign w_shift = r_cnt - 3'd1;
    assign w_trial = {{(DivW + 1 - CellMvW){1'b0}}, r_dvs} << w_shift;
    assign w_ge    = {1'b0, r_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DivSteps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if ((r_cnt == DivSteps && w_ge) || r_cnt == 3'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_busy && w_ge) begin
            if (r_cnt == DivSteps) begin
                r_quo <= QuoSat;
            end else begin
                r_rem                <= r_rem - w_trial[DivW-1:0];
                r_quo[w_shift[1:0]]  <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hw/rtl/bucd_regs.sv
// Configuration register file behind the APB-style port.
module bucd_regs
    import bucd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg            r_cfg;
    logic [IdxW-1:0] w_idx;
    logic            w_wr;

    assign w_idx  = paddr[AddrW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_full_mv    <= RstFullMv;
            r_cfg.cell_cutoff_mv  <= RstCutoffMv;
            r_cfg.cell_recover_mv <= RstRecoverMv;
            r_cfg.debounce_ms     <= RstDebMs;
            r_cfg.min_cells       <= RstMinCells;
            r_cfg.max_cells       <= RstMaxCells;
        end else if (w_wr) begin
            case (w_idx)
                RegFullMv:    r_cfg.cell_full_mv    <= pwdata[CellMvW-1:0];
                RegCutoffMv:  r_cfg.cell_cutoff_mv  <= pwdata[CellMvW-1:0];
                RegRecoverMv: r_cfg.cell_recover_mv <= pwdata[CellMvW-1:0];
                RegDebMs:     r_cfg.debounce_ms     <= pwdata[DebW-1:0];
                RegMinCells:  r_cfg.min_cells       <= pwdata[CountW-1:0];
                RegMaxCells:  r_cfg.max_cells       <= pwdata[CountW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            RegFullMv:    prdata = {{(DataW - CellMvW){1'b0}}, r_cfg.cell_full_mv};
            RegCutoffMv:  prdata = {{(DataW - CellMvW){1'b0}}, r_cfg.cell_cutoff_mv};
            RegRecoverMv: prdata = {{(DataW - CellMvW){1'b0}}, r_cfg.cell_recover_mv};
            RegDebMs:     prdata = {{(DataW - DebW){1'b0}}, r_cfg.debounce_ms};
            RegMinCells:  prdata = {{(DataW - CountW){1'b0}}, r_cfg.min_cells};
            RegMaxCells:  prdata = {{(DataW - CountW){1'b0}}, r_cfg.max_cells};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/bucd_ctrl.sv
// Controller state machine that sequences scaling, detection, ticks and the output word.
module bucd_ctrl
    import bucd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCALE1 = 8'b0000_0010,
        S_SCALE2 = 8'b0000_0100,
        S_BRANCH = 8'b0000_1000,
        S_DIVA   = 8'b0001_0000,
        S_DIVB   = 8'b0010_0000,
        S_LEVELS = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SCALE1;
                end
            end
            S_SCALE1: begin
                o_cmd.scale_mul = 1'b1;
                n_state         = S_SCALE2;
            end
            S_SCALE2: begin
                o_cmd.scale_div = 1'b1;
                n_state         = S_BRANCH;
            end
            S_BRANCH: begin
                if (i_status.opcode) begin
                    o_cmd.tick_upd = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.div_start_a = 1'b1;
                    n_state           = S_DIVA;
                end
            end
            S_DIVA: begin
                if (i_status.div_done) begin
                    o_cmd.take_a      = 1'b1;
                    o_cmd.div_start_b = 1'b1;
                    n_state           = S_DIVB;
                end
            end
            S_DIVB: begin
                if (i_status.div_done) begin
                    o_cmd.detect_fin = 1'b1;
                    n_state          = S_LEVELS;
                end
            end
            S_LEVELS: begin
                o_cmd.levels = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> hw/rtl/bucd_dp.sv
// Datapath: bus scaling, cell count detection, pack levels, lockout state and output word.
module bucd_dp
    import bucd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  t_cfg              i_cfg,
    input  logic              i_opcode,
    input  logic [AdcW-1:0]   i_adc_mv,
    input  logic [StampW-1:0] i_now_ms,
    output logic              o_uvlo_active,
    output logic [CountW-1:0] o_cell_count,
    output logic [BusW-1:0]   o_bus_mv,
    output logic [LevelW-1:0] o_cutoff_mv,
    output logic [LevelW-1:0] o_recover_mv,
    output logic              o_below_pending
);

    logic              r_opcode;
    logic [AdcW-1:0]   r_adc;
    logic [StampW-1:0] r_now;
    logic [ProdW-1:0]  r_prod;
    logic [BusW-1:0]   r_bus;
    logic [CountW-1:0] r_qa;

    logic              r_armed;
    logic              r_lockout;
    logic              r_pending;
    logic [StampW-1:0] r_below_start;
    logic [CountW-1:0] r_cells;
    logic [LevelW-1:0] r_pack_cutoff;
    logic [LevelW-1:0] r_pack_recover;
    logic [BusW-1:0]   r_last_bus;

    logic              r_o_uvlo;
    logic [CountW-1:0] r_o_cells;
    logic [BusW-1:0]   r_o_bus;
    logic [LevelW-1:0] r_o_cutoff;
    logic [LevelW-1:0] r_o_recover;
    logic              r_o_pending;

    logic [ScaledW-1:0] w_scaled;
    logic               w_div_start;
    logic [DivW-1:0]    w_dividend;
    logic [CellMvW-1:0] w_divisor;
    logic               w_div_done;
    logic [QuoW-1:0]    w_quo;
    logic [CountW-1:0]  w_qb;
    logic [CountW-1:0]  w_max_ab;
    logic [CountW-1:0]  w_count;
    logic [LevelW-1:0]  w_lvl_cut;
    logic [LevelW-1:0]  w_lvl_rec;
    logic [StampW-1:0]  w_elapsed;
    logic [LevelW-1:0]  w_bus_ext;

    assign w_scaled = ScaledW'(r_prod) * ScaledW'(RecipM);

    assign w_div_start = i_cmd.div_start_a || i_cmd.div_start_b;
    assign w_dividend  = i_cmd.div_start_a
                       ? ({1'b0, r_bus} + {{(DivW - CellMvW){1'b0}}, i_cfg.cell_full_mv}
                          - DivW'(1))
                       : {1'b0, r_bus};
    assign w_divisor   = i_cmd.div_start_a ? i_cfg.cell_full_mv : i_cfg.cell_cutoff_mv;

    bucd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    assign w_qb     = clamp_count(w_quo, i_cfg.min_cells, i_cfg.max_cells);
    assign w_max_ab = (r_qa > w_qb) ? r_qa : w_qb;
    assign w_count  = (r_bus == '0) ? i_cfg.min_cells
                    : clamp_count({1'b0, w_max_ab}, i_cfg.min_cells, i_cfg.max_cells);

    assign w_lvl_cut = {{(LevelW - CountW){1'b0}}, r_cells}
                     * {{(LevelW - CellMvW){1'b0}}, i_cfg.cell_cutoff_mv};
    assign w_lvl_rec = {{(LevelW - CountW){1'b0}}, r_cells}
                     * {{(LevelW - CellMvW){1'b0}}, i_cfg.cell_recover_mv};

    assign w_elapsed = r_now - r_below_start;
    assign w_bus_ext = {1'b0, r_bus};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_opcode <= i_opcode;
            r_adc    <= i_adc_mv;
            r_now    <= i_now_ms;
        end
        if (i_cmd.scale_mul) begin
            r_prod <= ProdW'(r_adc) * ProdW'(MulAdc);
        end
        if (i_cmd.scale_div) begin
            r_bus <= w_scaled[ScaleSh+BusW-1:ScaleSh];
        end
        if (i_cmd.take_a) begin
            r_qa <= clamp_count(w_quo, i_cfg.min_cells, i_cfg.max_cells);
        end
        if (i_cmd.out_load) begin
            r_o_uvlo    <= r_lockout;
            r_o_cells   <= r_cells;
            r_o_bus     <= r_last_bus;
            r_o_cutoff  <= r_pack_cutoff;
            r_o_recover <= r_pack_recover;
            r_o_pending <= r_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_lockout      <= 1'b0;
            r_pending      <= 1'b0;
            r_below_start  <= '0;
            r_cells        <= RstMinCells;
            r_pack_cutoff  <= '0;
            r_pack_recover <= '0;
            r_last_bus     <= '0;
        end else if (i_cmd.detect_fin) begin
            r_cells       <= w_count;
            r_lockout     <= 1'b0;
            r_pending     <= 1'b0;
            r_below_start <= '0;
            r_last_bus    <= r_bus;
            r_armed       <= 1'b1;
        end else if (i_cmd.levels) begin
            r_pack_cutoff  <= w_lvl_cut;
            r_pack_recover <= w_lvl_rec;
        end else if (i_cmd.tick_upd) begin
            if (!r_armed) begin
                r_last_bus <= '0;
            end else begin
                r_last_bus <= r_bus;
                if (r_lockout) begin
                    if (w_bus_ext >= r_pack_recover) begin
                        r_lockout <= 1'b0;
                    end
                    r_pending     <= 1'b0;
                    r_below_start <= '0;
                end else if (w_bus_ext < r_pack_cutoff) begin
                    if (!r_pending) begin
                        r_pending     <= 1'b1;
                        r_below_start <= r_now;
                    end else if (w_elapsed >= {{(StampW - DebW){1'b0}}, i_cfg.debounce_ms}) begin
                        r_lockout     <= 1'b1;
                        r_pending     <= 1'b0;
                        r_below_start <= '0;
                    end
                end else begin
                    r_pending     <= 1'b0;
                    r_below_start <= '0;
                end
            end
        end
    end

    assign o_status.opcode   = r_opcode;
    assign o_status.div_done = w_div_done;

    assign o_uvlo_active   = r_o_uvlo;
    assign o_cell_count    = r_o_cells;
    assign o_bus_mv        = r_o_bus;
    assign o_cutoff_mv     = r_o_cutoff;
    assign o_recover_mv    = r_o_recover;
    assign o_below_pending = r_o_pending;

endmodule

>>> hw/rtl/battery_uvlo_cell_detect_core.sv
// Top level of the battery undervoltage lockout and series cell detection block.
// Each input word carries an ADC pin voltage, scaled to bus millivolts by two registered
// multiplications, and yields one result word. A tick word passes the scaling, branch
// and finish states; a detection word also uses the shared divider, which makes two passes
// for the full-charge and cutoff quotients, and the levels state. One word is worked on at
// a time, and the next is accepted as soon as the result has been placed in the output
// register, even while it waits to be taken. The user must write the configuration registers
// through the APB-style port only while the block is idle; the block does not enforce this.
module battery_uvlo_cell_detect_core
    import bucd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [AdcW-1:0]   i_adc_mv,
    input  logic [StampW-1:0] i_now_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_uvlo_active,
    output logic [CountW-1:0] o_cell_count,
    output logic [BusW-1:0]   o_bus_mv,
    output logic [LevelW-1:0] o_cutoff_mv,
    output logic [LevelW-1:0] o_recover_mv,
    output logic              o_below_pending
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    bucd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bucd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bucd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg           (w_cfg),
        .i_opcode        (i_opcode),
        .i_adc_mv        (i_adc_mv),
        .i_now_ms        (i_now_ms),
        .o_uvlo_active   (o_uvlo_active),
        .o_cell_count    (o_cell_count),
        .o_bus_mv        (o_bus_mv),
        .o_cutoff_mv     (o_cutoff_mv),
        .o_recover_mv    (o_recover_mv),
        .o_below_pending (o_below_pending)
    );

endmodule

>>> hw/rtl/bucd_checker.sv
// Port-level assertions for the lockout block and the bind that attaches them.
module bucd_checker
    import bucd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_uvlo_active,
    input logic [CountW-1:0] o_cell_count,
    input logic [BusW-1:0]   o_bus_mv,
    input logic [LevelW-1:0] o_cutoff_mv,
    input logic [LevelW-1:0] o_recover_mv,
    input logic              o_below_pending
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_uvlo_active) && $stable(o_cell_count)
            && $stable(o_bus_mv) && $stable(o_cutoff_mv) && $stable(o_recover_mv)
            && $stable(o_below_pending))
        else $error("Result word changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("A second word was offered while one is still being worked on.");

    a_lock_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_uvlo_active && o_below_pending))
        else $error("Lockout and a running debounce reported together.");

    a_bus_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bus_mv <= BusMax)
        else $error("Bus voltage beyond the largest scaled ADC value.");

endmodule

bind battery_uvlo_cell_detect_core bucd_checker u_bucd_checker (.*);

>>> dv/tb_bucd_pkg.sv
`timescale 1ns / 1ps
// Opcodes, spare register index and result word layout shared by the testbench files.
package tb_bucd_pkg;

    import bucd_pkg::*;

    localparam logic OpDetect = 1'b0;
    localparam logic OpTick   = 1'b1;

    localparam logic [IdxW-1:0] RegSpare = 3'd6;

    typedef struct packed {
        logic              uvlo_active;
        logic [CountW-1:0] cell_count;
        logic [BusW-1:0]   bus_mv;
        logic [LevelW-1:0] cutoff_mv;
        logic [LevelW-1:0] recover_mv;
        logic              below_pending;
    } t_uvlo_status;

endpackage

>>> dv/battery_uvlo_cell_detect_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every result word of the lockout block and compares it on delivery.
module battery_uvlo_cell_detect_checker
    import bucd_pkg::*;
    import tb_bucd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    input  logic              pready,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic              i_opcode,
    input  logic [AdcW-1:0]   i_adc_mv,
    input  logic [StampW-1:0] i_now_ms,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic              o_uvlo_active,
    input  logic [CountW-1:0] o_cell_count,
    input  logic [BusW-1:0]   o_bus_mv,
    input  logic [LevelW-1:0] o_cutoff_mv,
    input  logic [LevelW-1:0] o_recover_mv,
    input  logic              o_below_pending,
    output int                o_fail_count,
    output int                o_outstanding
);

    logic [CellMvW-1:0] full_mv, cutoff_mv, recover_mv;
    logic [DebW-1:0]    deb_ms;
    logic [CountW-1:0]  min_cnt, max_cnt;

    logic               armed, locked, deb_running;
    logic [StampW-1:0]  low_since;
    logic [CountW-1:0]  cells;
    logic [LevelW-1:0]  pack_cutoff, pack_recover;
    logic [BusW-1:0]    last_bus;

    t_uvlo_status       status_q[$];

    function automatic logic [31:0] limit_count(input logic [31:0] v);
        if (v < {28'd0, min_cnt}) begin
            return {28'd0, min_cnt};
        end
        if (v > {28'd0, max_cnt}) begin
            return {28'd0, max_cnt};
        end
        return v;
    endfunction

    function automatic logic [CountW-1:0] infer_cells(input logic [31:0] bus);
        logic [31:0] by_full, by_cutoff, pick;
        if (bus == 32'd0) begin
            return min_cnt;
        end
        by_full   = (full_mv == '0) ? 32'hFFFF_FFFF : (bus + {19'd0, full_mv} - 32'd1) / {19'd0, full_mv};
        by_cutoff = (cutoff_mv == '0) ? 32'hFFFF_FFFF : bus / {19'd0, cutoff_mv};
        by_full   = limit_count(by_full);
        by_cutoff = limit_count(by_cutoff);
        pick      = limit_count((by_full > by_cutoff) ? by_full : by_cutoff);
        return pick[CountW-1:0];
    endfunction

    function automatic t_uvlo_status advance_monitor(input logic op,
                                                     input logic [AdcW-1:0] adc,
                                                     input logic [StampW-1:0] now);
        logic [31:0]  bus, prod;
        t_uvlo_status st;
        bus = ({20'd0, adc} * 32'd437) / 32'd47;
        if (op == OpDetect) begin
            cells        = infer_cells(bus);
            prod         = {28'd0, cells} * {19'd0, cutoff_mv};
            pack_cutoff  = prod[LevelW-1:0];
            prod         = {28'd0, cells} * {19'd0, recover_mv};
            pack_recover = prod[LevelW-1:0];
            locked       = 1'b0;
            deb_running  = 1'b0;
            low_since    = '0;
            last_bus     = bus[BusW-1:0];
            armed        = 1'b1;
        end else if (!armed) begin
            last_bus = '0;
        end else begin
            last_bus = bus[BusW-1:0];
            if (locked) begin
                if (bus >= {15'd0, pack_recover}) begin
                    locked = 1'b0;
                end
                deb_running = 1'b0;
                low_since   = '0;
            end else if (bus < {15'd0, pack_cutoff}) begin
                if (!deb_running) begin
                    deb_running = 1'b1;
                    low_since   = now;
                end else if ((now - low_since) >= {16'd0, deb_ms}) begin
                    locked      = 1'b1;
                    deb_running = 1'b0;
                    low_since   = '0;
                end
            end else begin
                deb_running = 1'b0;
                low_since   = '0;
            end
        end
        st.uvlo_active   = locked;
        st.cell_count    = cells;
        st.bus_mv        = last_bus;
        st.cutoff_mv     = pack_cutoff;
        st.recover_mv    = pack_recover;
        st.below_pending = deb_running;
        return st;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_uvlo_status seen, want;
        if (!i_rst_n) begin
            full_mv      = RstFullMv;
            cutoff_mv    = RstCutoffMv;
            recover_mv   = RstRecoverMv;
            deb_ms       = RstDebMs;
            min_cnt      = RstMinCells;
            max_cnt      = RstMaxCells;
            armed        = 1'b0;
            locked       = 1'b0;
            deb_running  = 1'b0;
            low_since    = '0;
            cells        = RstMinCells;
            pack_cutoff  = '0;
            pack_recover = '0;
            last_bus     = '0;
            status_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[AddrW-1:2])
                    RegFullMv:    full_mv    = pwdata[CellMvW-1:0];
                    RegCutoffMv:  cutoff_mv  = pwdata[CellMvW-1:0];
                    RegRecoverMv: recover_mv = pwdata[CellMvW-1:0];
                    RegDebMs:     deb_ms     = pwdata[DebW-1:0];
                    RegMinCells:  min_cnt    = pwdata[CountW-1:0];
                    RegMaxCells:  max_cnt    = pwdata[CountW-1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                seen = {o_uvlo_active, o_cell_count, o_bus_mv, o_cutoff_mv, o_recover_mv,
                        o_below_pending};
                if (status_q.size() == 0) begin
                    $display("%0t: result word expected none actual %p", $time, seen);
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    report_field("uvlo_active", want.uvlo_active, seen.uvlo_active);
                    report_field("cell_count", want.cell_count, seen.cell_count);
                    report_field("bus_mv", want.bus_mv, seen.bus_mv);
                    report_field("cutoff_mv", want.cutoff_mv, seen.cutoff_mv);
                    report_field("recover_mv", want.recover_mv, seen.recover_mv);
                    report_field("below_pending", want.below_pending, seen.below_pending);
                end
            end
            if (i_valid && o_ready) begin
                status_q.push_back(advance_monitor(i_opcode, i_adc_mv, i_now_ms));
            end
        end
        o_outstanding = status_q.size();
    end

endmodule

>>> dv/tb_battery_uvlo_cell_detect_core.sv
`timescale 1ns / 1ps
// Top of the lockout block testbench: clock, reset, register writes, stimulus and verdict.
module tb_battery_uvlo_cell_detect_core;

    import bucd_pkg::*;
    import tb_bucd_pkg::*;

    localparam int CycleLimit  = 1_000_000;
    localparam int DrainCycles = 24;
    localparam int LongHold    = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;
    logic              i_valid, o_ready;
    logic              i_opcode;
    logic [AdcW-1:0]   i_adc_mv;
    logic [StampW-1:0] i_now_ms;
    logic              o_valid, i_ready;
    logic              o_uvlo_active;
    logic [CountW-1:0] o_cell_count;
    logic [BusW-1:0]   o_bus_mv;
    logic [LevelW-1:0] o_cutoff_mv, o_recover_mv;
    logic              o_below_pending;

    int                fail_count;
    int                outstanding;
    int                cycle_cnt;
    bit                quiet;
    bit                long_hold_req;
    logic [StampW-1:0] stamp;
    int unsigned       cfg_cut, cfg_rec, cfg_deb, cfg_min, cfg_max;

    battery_uvlo_cell_detect_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_adc_mv        (i_adc_mv),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_uvlo_active   (o_uvlo_active),
        .o_cell_count    (o_cell_count),
        .o_bus_mv        (o_bus_mv),
        .o_cutoff_mv     (o_cutoff_mv),
        .o_recover_mv    (o_recover_mv),
        .o_below_pending (o_below_pending)
    );

    battery_uvlo_cell_detect_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_adc_mv        (i_adc_mv),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_uvlo_active   (o_uvlo_active),
        .o_cell_count    (o_cell_count),
        .o_bus_mv        (o_bus_mv),
        .o_cutoff_mv     (o_cutoff_mv),
        .o_recover_mv    (o_recover_mv),
        .o_below_pending (o_below_pending),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CycleLimit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("battery_uvlo_cell_detect_core regression: fail");
        $finish;
    end

    function automatic int idle_len(input int longest);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, longest);
    endfunction

    function automatic logic [AdcW-1:0] clip_adc(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 4095) begin
            return '1;
        end
        return v[AdcW-1:0];
    endfunction

    // The receiver stalls on its own; a long hold-off is requested by the stimulus.
    initial begin
        int hold_cnt;
        int stall;
        hold_cnt = 0;
        i_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                i_ready <= 1'b0;
                hold_cnt--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready  <= 1'b0;
                hold_cnt = LongHold;
            end else begin
                stall = idle_len(60);
                if (stall > 0) begin
                    i_ready  <= 1'b0;
                    hold_cnt = stall - 1;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_word(input logic op, input logic [AdcW-1:0] adc,
                             input logic [StampW-1:0] now);
        int gap;
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_adc_mv <= adc;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        gap = idle_len(40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [DataW-1:0] full, input logic [DataW-1:0] cut,
                              input logic [DataW-1:0] rec, input logic [DataW-1:0] deb,
                              input logic [DataW-1:0] minc, input logic [DataW-1:0] maxc);
        wait_idle();
        apb_write(RegFullMv, full);
        apb_write(RegCutoffMv, cut);
        apb_write(RegRecoverMv, rec);
        apb_write(RegDebMs, deb);
        apb_write(RegMinCells, minc);
        apb_write(RegMaxCells, maxc);
        cfg_cut = cut[CellMvW-1:0];
        cfg_rec = rec[CellMvW-1:0];
        cfg_deb = deb[DebW-1:0];
        cfg_min = minc[CountW-1:0];
        cfg_max = maxc[CountW-1:0];
    endtask

    // Mostly a detection word followed by a run of ticks hovering around the pack levels.
    task automatic run_phase(input int n);
        int          done, ticks, k, lo, hi, cut_adc, rec_adc, sel;
        logic [AdcW-1:0]   a_lo, a_hi;
        logic [StampW-1:0] step;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(1'($urandom_range(0, 1)), AdcW'($urandom_range(0, 4095)),
                          $urandom());
                done++;
            end else begin
                lo = (cfg_min < cfg_max) ? cfg_min : cfg_max;
                hi = (cfg_min < cfg_max) ? cfg_max : cfg_min;
                if (lo < 1) begin
                    lo = 1;
                end
                if (hi < lo) begin
                    hi = lo;
                end
                k       = $urandom_range(lo, hi);
                cut_adc = k * int'(cfg_cut) * 47 / 437;
                rec_adc = k * int'(cfg_rec) * 47 / 437;
                send_word(OpDetect, clip_adc(cut_adc + int'($urandom_range(0, 400)) - 200),
                          stamp);
                a_lo  = clip_adc(((cut_adc < rec_adc) ? cut_adc : rec_adc) - 150);
                a_hi  = clip_adc(((cut_adc < rec_adc) ? rec_adc : cut_adc) + 150);
                ticks = $urandom_range(4, 30);
                repeat (ticks) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 50) begin
                        step = $urandom_range(0, 3);
                    end else if (sel < 80) begin
                        step = $urandom_range(0, cfg_deb);
                    end else if (sel < 95) begin
                        step = cfg_deb + $urandom_range(0, 3);
                    end else begin
                        step = $urandom();
                    end
                    stamp = stamp + step;
                    send_word(OpTick, AdcW'($urandom_range(a_lo, a_hi)), stamp);
                end
                done += 1 + ticks;
            end
        end
    endtask

    initial begin
        int unsigned minc;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_opcode      = OpDetect;
        i_adc_mv      = '0;
        i_now_ms      = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        stamp         = $urandom();
        cfg_cut       = RstCutoffMv;
        cfg_rec       = RstRecoverMv;
        cfg_deb       = RstDebMs;
        cfg_min       = RstMinCells;
        cfg_max       = RstMaxCells;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Ticks before arming, then a full debounce, lockout and release cycle.
        send_word(OpTick, 12'd4095, 32'hFFFF_FFFF);
        send_word(OpTick, 12'd0, 32'd0);
        send_word(OpDetect, 12'd0, 32'd0);
        send_word(OpDetect, 12'd4095, 32'hFFFF_FFFF);
        send_word(OpDetect, 12'd2000, 32'd0);
        send_word(OpTick, 12'd1500, 32'd1000);
        send_word(OpTick, 12'd1500, 32'd1050);
        send_word(OpTick, 12'd1500, 32'd1100);
        send_word(OpTick, 12'd1800, 32'd1101);
        send_word(OpTick, 12'd1900, 32'd1102);
        send_word(OpTick, 12'd1500, 32'd2000);
        send_word(OpTick, 12'd1900, 32'd2010);
        send_word(OpTick, 12'd1500, 32'hFFFF_FFC0);
        send_word(OpTick, 12'd1500, 32'h0000_0030);
        send_word(OpTick, 12'd4095, 32'd0);
        send_word(OpTick, 12'd0, 32'hFFFF_FFFF);
        send_word(OpDetect, 12'd2000, 32'd5);

        // Zero per-cell levels saturate their quotients.
        set_config(32'd0, 32'd0, 32'd3500, 32'd0, 32'd2, 32'd9);
        send_word(OpDetect, 12'd1000, 32'd0);
        send_word(OpDetect, 12'd0, 32'd0);
        // Inverted cell range with no debounce delay.
        set_config(32'd4200, 32'd3300, 32'd3500, 32'd0, 32'd9, 32'd3);
        send_word(OpDetect, 12'd2000, 32'd0);
        send_word(OpTick, 12'd0, 32'd5);
        send_word(OpTick, 12'd0, 32'd5);
        // A minimum of zero cells.
        set_config(32'd4200, 32'd3300, 32'd3500, 32'd100, 32'd0, 32'd0);
        send_word(OpDetect, 12'd0, 32'd0);
        send_word(OpDetect, 12'd2000, 32'd0);
        send_word(OpTick, 12'd100, 32'd7);

        set_config(RstFullMv, RstCutoffMv, RstRecoverMv, RstDebMs, RstMinCells, RstMaxCells);
        long_hold_req = 1'b1;
        run_phase(190);
        set_config(32'd3000, 32'd2500, 32'd4500, 32'd0, 32'd1, 32'd15);
        run_phase(180);
        set_config(32'd4500, 32'd4500, 32'd2500, 32'd65535, 32'd15, 32'd15);
        run_phase(180);
        set_config('1, '1, '1, '1, '1, '1);
        apb_write(RegSpare, $urandom());
        quiet = 1'b1;
        run_phase(150);
        quiet = 1'b0;
        minc = $urandom_range(1, 15);
        set_config($urandom_range(3000, 4500), $urandom_range(2500, 4500),
                   $urandom_range(2500, 4500), $urandom_range(0, 300), minc,
                   $urandom_range(minc, 15));
        run_phase(180);
        minc = $urandom_range(1, 15);
        set_config($urandom_range(3000, 4500), $urandom_range(2500, 4500),
                   $urandom_range(2500, 4500), $urandom_range(0, 65535), minc,
                   $urandom_range(minc, 15));
        run_phase(180);
        set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        run_phase(180);

        wait_idle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("battery_uvlo_cell_detect_core regression: pass");
        end else begin
            $display("battery_uvlo_cell_detect_core regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/bucd_pkg.sv
hw/rtl/bucd_div.sv
hw/rtl/bucd_regs.sv
hw/rtl/bucd_ctrl.sv
hw/rtl/bucd_dp.sv
hw/rtl/battery_uvlo_cell_detect_core.sv
hw/rtl/bucd_checker.sv
dv/tb_bucd_pkg.sv
dv/battery_uvlo_cell_detect_checker.sv
dv/tb_battery_uvlo_cell_detect_core.sv
